FILE: rtl/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg
// Shared widths, constants and the arctangent table of the tilt angle block.
// ----------------------------------------------------------------------------
package ata_pkg;

	localparam int SAMPLE_W = 13;
	localparam int ANGLE_W  = 11;
	localparam int FRAC     = 18;
	localparam int STEPS    = 32;
	localparam int ATAN_W   = 50;
	localparam int SCALE_LO = 30;
	localparam int RECIP_SH = 40;

	localparam logic [63:0] PI_E15   = 64'd3141592653589793;
	localparam logic [63:0] HALF_PI  = 64'd1570796326794896;
	localparam logic [63:0] Q_E15    = 64'd1000000000000000;
	localparam logic [10:0] ANG_MAX  = 11'd900;
	localparam logic [10:0] DEG_SCALE = 11'd1800;
	localparam logic [19:0] PI_RECIP = 20'((128'd1 << (SCALE_LO + RECIP_SH)) / 128'(PI_E15));

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [ANGLE_W-1:0]  angle_t;
	typedef logic [ATAN_W-1:0]          atan_t;
	typedef atan_t                      atan_tab_t [STEPS];

	function automatic atan_tab_t build_atan();
		atan_tab_t   t;
		logic [63:0] v;
		t[0]  = ATAN_W'(64'd785398163397448);
		t[1]  = ATAN_W'(64'd463647609000806);
		t[2]  = ATAN_W'(64'd244978663126864);
		t[3]  = ATAN_W'(64'd124354994546761);
		t[4]  = ATAN_W'(64'd62418809995957);
		t[5]  = ATAN_W'(64'd31239833430268);
		t[6]  = ATAN_W'(64'd15623728620477);
		t[7]  = ATAN_W'(64'd7812341060101);
		t[8]  = ATAN_W'(64'd3906230131967);
		t[9]  = ATAN_W'(64'd1953122516479);
		t[10] = ATAN_W'(64'd976562189559);
		for (int i = 11; i < STEPS; i++) begin
			v = Q_E15 >> i;
			if (3 * i < 60) begin
				v = v - ((Q_E15 >> (3 * i)) / 3);
			end
			t[i] = ATAN_W'(v);
		end
		return t;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

FILE: rtl/ata_in_if.sv
// ----------------------------------------------------------------------------
// ata_in_if
// Sample channel: one three-axis accelerometer sample per transfer.
// ----------------------------------------------------------------------------
interface ata_in_if;
	logic                 valid;
	logic                 ready;
	ata_pkg::sample_t     sample_x;
	ata_pkg::sample_t     sample_y;
	ata_pkg::sample_t     sample_z;

	modport source (output valid, sample_x, sample_y, sample_z, input ready);
	modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

FILE: rtl/ata_out_if.sv
// ----------------------------------------------------------------------------
// ata_out_if
// Angle channel: roll, pitch and yaw in tenths of a degree per transfer.
// ----------------------------------------------------------------------------
interface ata_out_if;
	logic                 valid;
	logic                 ready;
	ata_pkg::angle_t      roll_tenths;
	ata_pkg::angle_t      pitch_tenths;
	ata_pkg::angle_t      yaw_tenths;

	modport source (output valid, roll_tenths, pitch_tenths, yaw_tenths, input ready);
	modport sink   (input valid, roll_tenths, pitch_tenths, yaw_tenths, output ready);
endinterface

FILE: rtl/accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles
// Block-averaged accelerometer samples to roll, pitch and yaw angles using
// a shared reciprocal multiply, square root, CORDIC and scaling step.
// ----------------------------------------------------------------------------
// Non-final sample of a block: summed in idle, next sample taken the following cycle.
// Final sample: input not ready while the block averages and squares the axes and
// runs the 32-step root and CORDIC loops once per angle, then loads the result; an angle
// with a zero numerator or denominator skips CORDIC and scaling.
// The result register frees the input side while a result waits.
// Reset clears the sums, block count, sequencer and output valid.
// ----------------------------------------------------------------------------
module accel_tilt_angles #(
	parameter int SAMPLES_AVERAGED = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	ata_in_if.sink    sample,
	ata_out_if.source angle
);
	import ata_pkg::*;

	localparam int LN  = $clog2(SAMPLES_AVERAGED);
	localparam int CW  = (LN > 0) ? LN : 1;
	localparam int SW  = SAMPLE_W + LN;
	localparam int KSH = SW + LN;
	localparam logic [SW:0] AVG_RECIP = (SW+1)'(((64'd1 << KSH) +
		64'(SAMPLES_AVERAGED) - 64'd1) / 64'(SAMPLES_AVERAGED));

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_AVG   = 4'd1;
	localparam logic [3:0] S_SQ    = 4'd2;
	localparam logic [3:0] S_PREP  = 4'd3;
	localparam logic [3:0] S_ROOT  = 4'd4;
	localparam logic [3:0] S_SEL   = 4'd5;
	localparam logic [3:0] S_CORD  = 4'd6;
	localparam logic [3:0] S_SCALE = 4'd7;
	localparam logic [3:0] S_DIV   = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	function automatic logic signed [35:0] sshr(input logic signed [35:0] v,
		input logic [4:0] s);
		logic [35:0] m;
		m = v[35] ? 36'(-v) : 36'(v);
		m = m >> s;
		return v[35] ? -$signed(m) : $signed(m);
	endfunction

	logic [3:0]             state_q;
	logic [5:0]             cnt_q;
	logic [CW-1:0]          blk_q;
	logic signed [SW-1:0]   acc_q [3];
	logic [SW-1:0]          dvd_q [3];
	logic                   sgn_q [3];
	logic [12:0]            mag_q [3];
	logic                   neg_q [3];
	logic [25:0]            sq_q [3];
	logic [1:0]             ang_q;
	logic [63:0]            rv_q;
	logic [63:0]            rres_q;
	logic [63:0]            bit_q;
	logic signed [35:0]     x_q;
	logic signed [35:0]     y_q;
	logic signed [52:0]     z_q;
	logic [63:0]            p_q;
	logic [10:0]            q_q;
	angle_t                 res_q [3];
	logic                   ov_q;
	angle_t                 roll_q;
	angle_t                 pitch_q;
	angle_t                 yaw_q;

	sample_t                smp [3];
	logic signed [SW-1:0]   new_sum [3];
	logic [2*SW:0]          avg_prod;
	logic [1:0]             lin_i;
	logic [26:0]            sq_all;
	logic [25:0]            sq_sel;
	logic [63:0]            trial;
	logic [63:0]            lm;
	logic [63:0]            num;
	logic [63:0]            den;
	logic                   on_top;
	logic signed [35:0]     xs;
	logic signed [35:0]     ys;
	logic signed [52:0]     atan_v;
	logic [53:0]            qe_prod;
	logic [63:0]            pis;
	logic [51:0]            zc;
	logic [10:0]            tq;
	logic                   take;

	assign smp[0] = sample.sample_x;
	assign smp[1] = sample.sample_y;
	assign smp[2] = sample.sample_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			new_sum[k] = acc_q[k] + SW'(smp[k]);
		end
	end

	always_comb begin
		case (ang_q)
			2'd0:    lin_i = 2'd1;
			2'd1:    lin_i = 2'd0;
			default: lin_i = 2'd2;
		endcase
	end

	assign avg_prod = (2*SW+1)'(dvd_q[cnt_q[1:0]]) * (2*SW+1)'(AVG_RECIP);
	assign sq_all  = 27'(sq_q[0]) + 27'(sq_q[1]) + 27'(sq_q[2]);
	assign sq_sel  = 26'(sq_all - 27'(sq_q[lin_i]));
	assign trial   = rres_q + bit_q;
	assign lm      = 64'(mag_q[lin_i]) << FRAC;
	assign on_top  = ang_q != 2'd2;
	assign num     = on_top ? lm : rres_q;
	assign den     = on_top ? rres_q : lm;
	assign xs      = sshr(x_q, cnt_q[4:0]);
	assign ys      = sshr(y_q, cnt_q[4:0]);
	assign atan_v  = 53'(ATAN_TAB[cnt_q[4:0]]);
	assign qe_prod = 54'(p_q >> SCALE_LO) * 54'(PI_RECIP);
	assign pis     = (64'(q_q) + 64'd1) * PI_E15;
	assign zc      = z_q[52] ? 52'd0 : 52'(z_q);
	assign tq      = (q_q > ANG_MAX) ? ANG_MAX : q_q;
	assign take    = sample.valid && sample.ready;

	assign sample.ready       = state_q == S_IDLE;
	assign angle.valid        = ov_q;
	assign angle.roll_tenths  = roll_q;
	assign angle.pitch_tenths = pitch_q;
	assign angle.yaw_tenths   = yaw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			blk_q   <= '0;
			ang_q   <= '0;
			ov_q    <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= '0;
			end
		end else begin
			if (ov_q && angle.ready && state_q != S_OUT) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (blk_q == CW'(SAMPLES_AVERAGED - 1)) begin
							blk_q <= '0;
							cnt_q <= '0;
							for (int k = 0; k < 3; k++) begin
								acc_q[k] <= '0;
								sgn_q[k] <= new_sum[k][SW-1];
								dvd_q[k] <= new_sum[k][SW-1] ? SW'(-new_sum[k])
									: SW'(new_sum[k]);
							end
							state_q <= S_AVG;
						end else begin
							blk_q <= blk_q + 1'b1;
							for (int k = 0; k < 3; k++) begin
								acc_q[k] <= new_sum[k];
							end
						end
					end
				end
				S_AVG: begin
					dvd_q[cnt_q[1:0]] <= SW'(avg_prod >> KSH);
					if (cnt_q == 6'd2) begin
						cnt_q   <= '0;
						state_q <= S_SQ;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SQ: begin
					if (cnt_q == 6'd0) begin
						for (int k = 0; k < 3; k++) begin
							mag_q[k] <= dvd_q[k][12:0];
							neg_q[k] <= sgn_q[k] && (dvd_q[k] != '0);
						end
					end
					sq_q[cnt_q[1:0]] <= 26'(dvd_q[cnt_q[1:0]][12:0]) *
						26'(dvd_q[cnt_q[1:0]][12:0]);
					if (cnt_q == 6'd2) begin
						ang_q   <= '0;
						state_q <= S_PREP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_PREP: begin
					rv_q    <= {2'b00, sq_sel, 36'd0};
					rres_q  <= '0;
					bit_q   <= 64'd1 << 62;
					cnt_q   <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (rv_q >= trial) begin
						rv_q   <= rv_q - trial;
						rres_q <= (rres_q >> 1) + bit_q;
					end else begin
						rres_q <= rres_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (cnt_q == 6'(STEPS - 1)) begin
						state_q <= S_SEL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SEL: begin
					cnt_q <= '0;
					x_q   <= 36'(den);
					y_q   <= 36'(num);
					z_q   <= '0;
					if (num == '0) begin
						q_q     <= '0;
						state_q <= S_FIN;
					end else if (den == '0) begin
						q_q     <= ANG_MAX;
						state_q <= S_FIN;
					end else begin
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (!y_q[35]) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_v;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_v;
					end
					if (cnt_q == 6'(STEPS - 1)) begin
						state_q <= S_SCALE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SCALE: begin
					p_q     <= 64'(zc) * 64'(DEG_SCALE) + HALF_PI;
					q_q     <= '0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == 6'd0) begin
						q_q   <= 11'(qe_prod >> RECIP_SH);
						cnt_q <= 6'd1;
					end else begin
						if (p_q >= pis) begin
							q_q <= q_q + 1'b1;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_q[ang_q] <= neg_q[lin_i] ? -$signed(tq) : $signed(tq);
					if (ang_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						ang_q   <= ang_q + 1'b1;
						state_q <= S_PREP;
					end
				end
				S_OUT: begin
					if (!ov_q || angle.ready) begin
						roll_q  <= res_q[0];
						pitch_q <= res_q[1];
						yaw_q   <= res_q[2];
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !sample.ready)
		else $error("sample channel ready while busy");

	a_valid_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(angle.valid) |-> ($past(state_q) == S_OUT))
		else $error("result valid raised outside the output step");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle.valid |-> (angle.roll_tenths <= 11'sd900 && angle.roll_tenths >= -11'sd900
			&& angle.yaw_tenths <= 11'sd900 && angle.yaw_tenths >= -11'sd900))
		else $error("angle out of range");

	a_cordic_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CORD || state_q == S_ROOT) |-> (cnt_q < 6'(STEPS)))
		else $error("iteration count overrun");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Block-averaged tilt angle check: samples go in through a driver fed from a
// queue, each completed block of eight is predicted in fixed point (vectoring
// CORDIC on the averaged axes), and the monitor checks every angle transfer
// in order, under several idle and stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ata_pkg::*;

	localparam int BLOCK_LEN   = 8;
	localparam int WATCH_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam int TAIL_CYCLES = 400;

	typedef struct packed {
		sample_t x;
		sample_t y;
		sample_t z;
	} accel_sample_t;

	typedef struct packed {
		angle_t roll;
		angle_t pitch;
		angle_t yaw;
	} tilt_t;

	logic clk;
	logic arst_n;

	ata_in_if  sample();
	ata_out_if angle();

	accel_tilt_angles #(.SAMPLES_AVERAGED(BLOCK_LEN)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.angle  (angle.source)
	);

	accel_sample_t pending_samples[$];
	tilt_t         expected_tilts[$];
	int            total_samples;
	int            sent_samples;
	int            errors;
	int            idle_cycles;
	int            hold_left;
	bit            hold_done;

	int sum_x, sum_y, sum_z, block_cnt;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint trunc_shift(longint v, int s);
		if (v < 0) return -longint'(64'(-v) >> s);
		return longint'(64'(v) >> s);
	endfunction

	function automatic angle_t tilt_angle(int lin, logic [63:0] sq, bit lin_on_top);
		logic [63:0] lin_mag, root_mag, num, den, t;
		longint      cx, cy, cz, xs, ys;
		bit          neg;
		neg      = lin < 0;
		lin_mag  = 64'(neg ? -lin : lin) << FRAC;
		root_mag = int_sqrt(sq << (2 * FRAC));
		num      = lin_on_top ? lin_mag : root_mag;
		den      = lin_on_top ? root_mag : lin_mag;
		if (num == 0) return '0;
		if (den == 0) return neg ? -angle_t'(900) : angle_t'(900);
		cx = longint'(den);
		cy = longint'(num);
		cz = 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = trunc_shift(cx, i);
			ys = trunc_shift(cy, i);
			if (cy >= 0) begin
				cx = cx + ys;
				cy = cy - xs;
				cz = cz + longint'(ATAN_TAB[i]);
			end else begin
				cx = cx - ys;
				cy = cy + xs;
				cz = cz - longint'(ATAN_TAB[i]);
			end
		end
		if (cz < 0) cz = 0;
		t = (64'(cz) * 64'd1800 + PI_E15 / 2) / PI_E15;
		if (t > 900) t = 900;
		return neg ? -angle_t'(t) : angle_t'(t);
	endfunction

	task automatic accumulate_sample(accel_sample_t s);
		int          ax, ay, az;
		logic [63:0] xx, yy, zz;
		tilt_t       r;
		sum_x = sum_x + int'(s.x);
		sum_y = sum_y + int'(s.y);
		sum_z = sum_z + int'(s.z);
		if (block_cnt + 1 < BLOCK_LEN) begin
			block_cnt++;
			return;
		end
		ax = sum_x / BLOCK_LEN;
		ay = sum_y / BLOCK_LEN;
		az = sum_z / BLOCK_LEN;
		sum_x = 0;
		sum_y = 0;
		sum_z = 0;
		block_cnt = 0;
		xx = 64'(longint'(ax) * ax);
		yy = 64'(longint'(ay) * ay);
		zz = 64'(longint'(az) * az);
		r.roll  = tilt_angle(ay, xx + zz, 1'b1);
		r.pitch = tilt_angle(ax, yy + zz, 1'b1);
		r.yaw   = tilt_angle(az, xx + yy, 1'b0);
		expected_tilts.push_back(r);
	endtask

	function automatic sample_t clip13(int v);
		if (v > 4095) return sample_t'(4095);
		if (v < -4096) return sample_t'(-4096);
		return sample_t'(v);
	endfunction

	function automatic int rand_axis();
		return int'($urandom_range(0, 8191)) - 4096;
	endfunction

	function automatic int phase_of(int n);
		return (n * 4) / (total_samples + 1);
	endfunction

	task automatic push_block(int bx, int by, int bz, int noise);
		accel_sample_t s;
		for (int i = 0; i < BLOCK_LEN; i++) begin
			s.x = clip13(bx + int'($urandom_range(0, 2 * noise)) - noise);
			s.y = clip13(by + int'($urandom_range(0, 2 * noise)) - noise);
			s.z = clip13(bz + int'($urandom_range(0, 2 * noise)) - noise);
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		int kind, bx, by, bz;
		accel_sample_t s;
		sum_x = 0;
		sum_y = 0;
		sum_z = 0;
		block_cnt = 0;
		errors = 0;
		sent_samples = 0;
		push_block(-4096, 0, 0, 0);
		push_block(0, 0, 0, 0);
		push_block(4095, 4095, 4095, 0);
		for (int b = 0; b < 135; b++) begin
			kind = $urandom_range(0, 99);
			bx = rand_axis();
			by = rand_axis();
			bz = rand_axis();
			if (kind < 60) begin
				push_block(bx, by, bz, $urandom_range(0, 64));
			end else if (kind < 75) begin
				push_block(0, 0, 0, 4096);
			end else if (kind < 85) begin
				case ($urandom_range(0, 5))
					0: bx = 0;
					1: by = 0;
					2: bz = 0;
					3: begin bx = 0; by = 0; end
					4: begin by = 0; bz = 0; end
					default: begin bx = 0; bz = 0; end
				endcase
				push_block(bx, by, bz, 0);
			end else if (kind < 93) begin
				push_block($urandom_range(0, 1) ? 4095 : -4096,
					$urandom_range(0, 1) ? 4095 : -4096,
					$urandom_range(0, 1) ? 4095 : -4096, 0);
			end else begin
				push_block($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
					$urandom_range(0, 8) - 4, 3);
			end
		end
		for (int i = 0; i < 3; i++) begin
			s.x = sample_t'(rand_axis());
			s.y = sample_t'(rand_axis());
			s.z = sample_t'(rand_axis());
			pending_samples.push_back(s);
		end
		total_samples = pending_samples.size();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (sent_samples == total_samples && expected_tilts.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_tilts.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		bit accepted, go;
		int ph;
		if (!arst_n) begin
			sample.valid    <= 1'b0;
			sample.sample_x <= '0;
			sample.sample_y <= '0;
			sample.sample_z <= '0;
		end else begin
			accepted = sample.valid && sample.ready;
			if (accepted) begin
				accumulate_sample({sample.sample_x, sample.sample_y, sample.sample_z});
				sent_samples++;
			end
			if (!sample.valid || accepted) begin
				ph = phase_of(sent_samples);
				go = pending_samples.size() != 0;
				if ((ph == 1 && $urandom_range(0, 99) < 80) ||
				    (ph == 3 && $urandom_range(0, 99) < 32)) begin
					go = 1'b0;
				end
				if (go) begin
					{sample.sample_x, sample.sample_y, sample.sample_z} <=
						pending_samples.pop_front();
					sample.valid <= 1'b1;
				end else begin
					sample.valid    <= 1'b0;
					sample.sample_x <= sample_t'($urandom);
					sample.sample_y <= sample_t'($urandom);
					sample.sample_z <= sample_t'($urandom);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		tilt_t want;
		int ph;
		if (!arst_n) begin
			angle.ready <= 1'b0;
			hold_left   = 0;
			hold_done   = 1'b0;
		end else begin
			if (angle.valid && angle.ready) begin
				if (expected_tilts.size() == 0) begin
					$error("unexpected angle transfer");
					errors++;
				end else begin
					want = expected_tilts.pop_front();
					if (angle.roll_tenths !== want.roll) begin
						$error("roll_tenths exp %0d got %0d", want.roll, angle.roll_tenths);
						errors++;
					end
					if (angle.pitch_tenths !== want.pitch) begin
						$error("pitch_tenths exp %0d got %0d", want.pitch,
							angle.pitch_tenths);
						errors++;
					end
					if (angle.yaw_tenths !== want.yaw) begin
						$error("yaw_tenths exp %0d got %0d", want.yaw, angle.yaw_tenths);
						errors++;
					end
				end
			end
			if (!hold_done && sent_samples >= 120) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			ph = phase_of(sent_samples);
			if (hold_left > 0) begin
				hold_left--;
				angle.ready <= 1'b0;
			end else if (ph == 2) begin
				angle.ready <= $urandom_range(0, 99) >= 80;
			end else if (ph == 3) begin
				angle.ready <= $urandom_range(0, 99) >= 32;
			end else begin
				angle.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((sample.valid && sample.ready) || (angle.valid && angle.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule
